[design/tbse_pkg.sv]
// shared types and constants for the tape block symbol encoder
package tbse_pkg;

    // tape symbol codes
    localparam logic [2:0] SYM_PILOT   = 3'd0;
    localparam logic [2:0] SYM_SYNC    = 3'd1;
    localparam logic [2:0] SYM_ZERO    = 3'd2;
    localparam logic [2:0] SYM_ONE     = 3'd3;
    localparam logic [2:0] SYM_Z81ZERO = 3'd4;
    localparam logic [2:0] SYM_Z81ONE  = 3'd5;
    localparam logic [2:0] SYM_SILENCE = 3'd6;

    // configuration register indexes
    localparam logic CFG_FAST_MODE   = 1'b0;
    localparam logic CFG_TAPE_FORMAT = 1'b1;

    // tape format codes
    localparam logic FMT_SPECTRUM = 1'b0;
    localparam logic FMT_ZX81     = 1'b1;

    // run lengths
    localparam logic [11:0] PILOT_FAST     = 12'd1200;
    localparam logic [11:0] PILOT_HEADER   = 12'd3000;
    localparam logic [11:0] PILOT_DATA     = 12'd1600;
    localparam logic [11:0] SYNC_LEN       = 12'd1;
    localparam logic [11:0] BIT_LEN        = 12'd1;
    localparam logic [11:0] SPEC_TAIL_LEN  = 12'd20;
    localparam logic [11:0] Z81_LEAD_LEN   = 12'd100;
    localparam logic [11:0] Z81_TAIL_LEN   = 12'd50;

    // command queue depth
    localparam int CMD_DEPTH   = 2;
    localparam int CMD_PTR_W   = 1;
    localparam int CMD_COUNT_W = 2;

    // classified work item passed from front to back
    typedef struct packed {
        logic        fmt;
        logic        has_pre;
        logic [11:0] pre_count;
        logic [7:0]  send;
        logic        has_post;
    } cmd_t;

endpackage

[design/tbse_front.sv]
// front end: configuration registers, running checksum and item classification
module tbse_front
    import tbse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic       cfg_data,
    input  logic       push,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic       last_byte,
    input  logic       q_full,
    output logic       q_wr,
    output cmd_t       q_wr_cmd
);

    logic       fast_mode_reg;
    logic       tape_format_reg;
    logic [7:0] xor_check_reg;
    logic [7:0] xor_check_next;
    logic [7:0] xor_base;
    logic [11:0] pilot_len;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_mode_reg   <= 1'b0;
            tape_format_reg <= FMT_SPECTRUM;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FAST_MODE:   fast_mode_reg   <= cfg_data;
                CFG_TAPE_FORMAT: tape_format_reg <= cfg_data;
                default:         fast_mode_reg   <= fast_mode_reg;
            endcase
        end
    end

    assign q_wr = push && !q_full;

    // classify the word and, in spectrum format, update the checksum
    always_comb
    begin
        xor_base       = first_byte ? 8'h00 : xor_check_reg;
        xor_check_next = xor_check_reg;
        pilot_len      = fast_mode_reg ? PILOT_FAST
                       : ((data_byte == 8'h00) ? PILOT_HEADER : PILOT_DATA);

        q_wr_cmd.fmt      = tape_format_reg;
        q_wr_cmd.has_pre  = first_byte;
        q_wr_cmd.has_post = last_byte;

        if (tape_format_reg == FMT_SPECTRUM)
        begin
            q_wr_cmd.pre_count = pilot_len;
            if (last_byte)
            begin
                q_wr_cmd.send  = xor_base;
                xor_check_next = 8'h00;
            end
            else
            begin
                q_wr_cmd.send  = data_byte;
                xor_check_next = xor_base ^ data_byte;
            end
        end
        else
        begin
            q_wr_cmd.pre_count = Z81_LEAD_LEN;
            q_wr_cmd.send      = data_byte;
        end
    end

    // running checksum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_check_reg <= 8'h00;
        end
        else if (q_wr)
        begin
            xor_check_reg <= xor_check_next;
        end
    end

endmodule

[design/tbse_cmd_queue.sv]
// two-entry command queue between front and back
module tbse_cmd_queue
    import tbse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  cmd_t wr_cmd,
    input  logic rd,
    output cmd_t rd_cmd,
    output logic full,
    output logic not_empty
);

    cmd_t                   mem_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0]   wr_ptr_reg;
    logic [CMD_PTR_W-1:0]   rd_ptr_reg;
    logic [CMD_COUNT_W-1:0] count_reg;
    logic [CMD_COUNT_W-1:0] count_next;

    assign full      = (count_reg == CMD_COUNT_W'(CMD_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_cmd    = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    // checks
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CMD_COUNT_W'(CMD_DEPTH))
        else $error("command queue over capacity");

    a_rd_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        rd |-> not_empty)
        else $error("command queue read while empty");

endmodule

[design/tbse_back.sv]
// back end: symbol sequencer and output register
module tbse_back
    import tbse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        q_rd_cmd,
    input  logic        q_not_empty,
    output logic        q_rd,
    input  logic        pop,
    output logic        empty,
    output logic [2:0]  symbol,
    output logic [11:0] repeat_count,
    output logic        run_end
);

    typedef enum logic [3:0] {
        PH_PRE  = 4'b0001,
        PH_SYNC = 4'b0010,
        PH_BITS = 4'b0100,
        PH_POST = 4'b1000
    } phase_t;

    cmd_t        cur_reg;
    logic        cur_valid_reg;
    phase_t      phase_reg;
    phase_t      phase_next;
    logic [2:0]  bit_cnt_reg;
    logic        out_valid_reg;
    logic [2:0]  sym_reg;
    logic [11:0] count_reg;
    logic        run_end_reg;

    logic [2:0]  sym_next;
    logic [11:0] count_next;
    logic        done_next;
    logic        cur_bit;
    logic        advance;
    logic        load;

    assign advance = cur_valid_reg && (!out_valid_reg || pop);
    assign load    = q_not_empty && (!cur_valid_reg || (advance && done_next));
    assign q_rd    = load;
    assign cur_bit = cur_reg.send[3'd7 - bit_cnt_reg];

    // next result word of the current command
    always_comb
    begin
        sym_next   = SYM_ZERO;
        count_next = BIT_LEN;
        done_next  = 1'b0;
        phase_next = phase_reg;
        case (phase_reg)
            PH_PRE:
            begin
                sym_next   = (cur_reg.fmt == FMT_ZX81) ? SYM_SILENCE : SYM_PILOT;
                count_next = cur_reg.pre_count;
                phase_next = (cur_reg.fmt == FMT_ZX81) ? PH_BITS : PH_SYNC;
            end
            PH_SYNC:
            begin
                sym_next   = SYM_SYNC;
                count_next = SYNC_LEN;
                phase_next = PH_BITS;
            end
            PH_BITS:
            begin
                if (cur_reg.fmt == FMT_ZX81)
                begin
                    sym_next = cur_bit ? SYM_Z81ONE : SYM_Z81ZERO;
                end
                else
                begin
                    sym_next = cur_bit ? SYM_ONE : SYM_ZERO;
                end
                count_next = BIT_LEN;
                if (bit_cnt_reg == 3'd7)
                begin
                    phase_next = PH_POST;
                    done_next  = !cur_reg.has_post;
                end
            end
            PH_POST:
            begin
                sym_next   = (cur_reg.fmt == FMT_ZX81) ? SYM_SILENCE : SYM_ZERO;
                count_next = (cur_reg.fmt == FMT_ZX81) ? Z81_TAIL_LEN : SPEC_TAIL_LEN;
                done_next  = 1'b1;
            end
            default:
            begin
                done_next = 1'b1;
            end
        endcase
    end

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            phase_reg     <= PH_BITS;
            bit_cnt_reg   <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                cur_valid_reg <= 1'b1;
                phase_reg     <= q_rd_cmd.has_pre ? PH_PRE : PH_BITS;
                bit_cnt_reg   <= 3'd0;
            end
            else if (advance)
            begin
                if (done_next)
                begin
                    cur_valid_reg <= 1'b0;
                end
                phase_reg <= phase_next;
                if (phase_reg == PH_BITS)
                begin
                    bit_cnt_reg <= bit_cnt_reg + 3'd1;
                end
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // current command and output word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= q_rd_cmd;
        end
        if (advance)
        begin
            sym_reg     <= sym_next;
            count_reg   <= count_next;
            run_end_reg <= done_next;
        end
    end

    assign empty        = !out_valid_reg;
    assign symbol       = sym_reg;
    assign repeat_count = count_reg;
    assign run_end      = run_end_reg;

    // checks
    a_post_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg && (phase_reg == PH_POST) |-> cur_reg.has_post)
        else $error("tail phase without last byte");

    a_sync_spectrum_only: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg && (phase_reg == PH_SYNC) |-> (cur_reg.fmt == FMT_SPECTRUM))
        else $error("sync phase in zx81 block");

    a_pilot_not_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (sym_reg == SYM_PILOT || sym_reg == SYM_SYNC) |-> !run_end_reg)
        else $error("pilot or sync marked as end of run");

endmodule

[design/tape_block_symbol_encoder_core.sv]
// top level of the tape block symbol encoder
//
//  channel   direction  handshake            payload
//  config    in         cfg_we               cfg_index, cfg_data
//  input     in         push / full          data_byte, first_byte, last_byte
//  result    out        empty / pop          symbol, repeat_count, run_end
//
// each byte gives 8 to 11 result words at one word per cycle from the back sequencer while pop is high
// a two-entry command queue lets the front take up to two bytes ahead of the sequencer
// on an idle block an accepted byte passes the command queue, the current command register and the output register
// reset clears the configuration, the checksum, the queue and the output register
// pop low holds the current word and stalls the sequencer; push stalls only on full
module tape_block_symbol_encoder_core
    import tbse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  symbol,
    output logic [11:0] repeat_count,
    output logic        run_end
);

    logic q_wr;
    cmd_t q_wr_cmd;
    logic q_rd;
    cmd_t q_rd_cmd;
    logic q_not_empty;

    // classify incoming bytes
    tbse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .q_full     (full),
        .q_wr       (q_wr),
        .q_wr_cmd   (q_wr_cmd)
    );

    // decoupling queue
    tbse_cmd_queue u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (q_wr),
        .wr_cmd    (q_wr_cmd),
        .rd        (q_rd),
        .rd_cmd    (q_rd_cmd),
        .full      (full),
        .not_empty (q_not_empty)
    );

    // emit symbol words
    tbse_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_rd_cmd     (q_rd_cmd),
        .q_not_empty  (q_not_empty),
        .q_rd         (q_rd),
        .pop          (pop),
        .empty        (empty),
        .symbol       (symbol),
        .repeat_count (repeat_count),
        .run_end      (run_end)
    );

endmodule

[tb/sv/tb_tape_block_symbol_encoder_core.sv]
// testbench for the tape block symbol encoder core: directed and random blocks checked word by word
module tb_tape_block_symbol_encoder_core;
    import tbse_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_CAP  = 30;

    // one expected tape run word
    typedef struct packed {
        logic [2:0]  symbol;
        logic [11:0] count;
        logic        run_end;
    } tape_run_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic        cfg_data = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = 8'h00;
    logic        first_byte = 1'b0;
    logic        last_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  symbol;
    logic [11:0] repeat_count;
    logic        run_end;

    // predictor state and expected words
    logic        fast_pilot = 1'b0;
    logic        cur_format = FMT_SPECTRUM;
    logic [7:0]  block_xor = 8'h00;
    tape_run_t   tape_run_q[$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int pop_stall_pct = 0;

    tape_block_symbol_encoder_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .first_byte   (first_byte),
        .last_byte    (last_byte),
        .empty        (empty),
        .pop          (pop),
        .symbol       (symbol),
        .repeat_count (repeat_count),
        .run_end      (run_end)
    );

    // clock
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_tape_block_symbol_encoder_core: FAIL");
            $finish;
        end
    end

    // receiver with random stalls
    always @(posedge clk)
        pop <= ($urandom_range(0, 99) >= pop_stall_pct);

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < REPORT_CAP)
            $display("mismatch %s: got %0d, expected %0d (cycle %0d)",
                     what, got, want, cycle_count);
        mismatch_count++;
    endtask

    function automatic void add_run(input logic [2:0] sym, input logic [11:0] cnt);
        tape_run_t w;
        w.symbol  = sym;
        w.count   = cnt;
        w.run_end = 1'b0;
        tape_run_q.push_back(w);
    endfunction

    // expected words for one accepted byte
    function automatic void encode_byte(input logic [7:0] d, input logic f, input logic l);
        logic [7:0] bits;
        logic [2:0] sym0;
        logic [2:0] sym1;
        logic       spectrum;
        tape_run_t  tail;
        spectrum = (cur_format == FMT_SPECTRUM);
        if (spectrum)
        begin
            // pilot length depends on the flag byte unless fast
            if (f)
            begin
                block_xor = 8'h00;
                if (fast_pilot)
                    add_run(SYM_PILOT, PILOT_FAST);
                else
                    add_run(SYM_PILOT, (d == 8'h00) ? PILOT_HEADER : PILOT_DATA);
                add_run(SYM_SYNC, SYNC_LEN);
            end
            // last slot carries the checksum
            if (l)
            begin
                bits = block_xor;
                block_xor = 8'h00;
            end
            else
            begin
                bits = d;
                block_xor = block_xor ^ d;
            end
            sym0 = SYM_ZERO;
            sym1 = SYM_ONE;
        end
        else
        begin
            if (f)
                add_run(SYM_SILENCE, Z81_LEAD_LEN);
            bits = d;
            sym0 = SYM_Z81ZERO;
            sym1 = SYM_Z81ONE;
        end
        for (int i = 7; i >= 0; i--)
            add_run(bits[i] ? sym1 : sym0, BIT_LEN);
        if (l)
        begin
            if (spectrum)
                add_run(SYM_ZERO, SPEC_TAIL_LEN);
            else
                add_run(SYM_SILENCE, Z81_TAIL_LEN);
        end
        tail = tape_run_q.pop_back();
        tail.run_end = 1'b1;
        tape_run_q.push_back(tail);
    endfunction

    // compare each popped word with the oldest expectation
    always @(posedge clk)
    begin
        tape_run_t want;
        if (rst_n && pop && !empty)
        begin
            if (tape_run_q.size() == 0)
                report_mismatch("unexpected word, symbol", int'(symbol), -1);
            else
            begin
                want = tape_run_q.pop_front();
                if (symbol !== want.symbol)
                    report_mismatch("symbol", int'(symbol), int'(want.symbol));
                if (repeat_count !== want.count)
                    report_mismatch("repeat_count", int'(repeat_count), int'(want.count));
                if (run_end !== want.run_end)
                    report_mismatch("run_end", int'(run_end), int'(want.run_end));
            end
        end
    end

    // send one byte, with an optional idle gap first
    task automatic send_byte(input logic [7:0] d, input logic f, input logic l);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        push       <= 1'b1;
        data_byte  <= d;
        first_byte <= f;
        last_byte  <= l;
        do
            @(posedge clk);
        while (full);
        encode_byte(d, f, l);
    endtask

    // stop sending and wait for every expected word
    task automatic drain;
        push <= 1'b0;
        while (tape_run_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_FAST_MODE)
            fast_pilot = val;
        else
            cur_format = val;
        @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        pop_stall_pct = stall_pct;
    endtask

    // header block after reset: zero flag gives the long pilot
    task automatic test_spectrum_header;
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b1);
        drain();
    endtask

    // data blocks, first and last together, bytes with no opening first
    task automatic test_spectrum_data_blocks;
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hC3, 1'b1, 1'b1);
        send_byte(8'h12, 1'b0, 1'b0);
        send_byte(8'h34, 1'b0, 1'b1);
        drain();
    endtask

    // fast pilot, and a register change in the middle of a block
    task automatic test_fast_pilot;
        write_reg(CFG_FAST_MODE, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h5A, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b0);
        drain();
        write_reg(CFG_FAST_MODE, 1'b0);
        send_byte(8'h96, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        drain();
    endtask

    // zx81 framing, no checksum
    task automatic test_zx81_blocks;
        write_reg(CFG_TAPE_FORMAT, FMT_ZX81);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h3C, 1'b0, 1'b1);
        send_byte(8'h81, 1'b1, 1'b1);
        send_byte(8'h7E, 1'b0, 1'b0);
        drain();
        write_reg(CFG_TAPE_FORMAT, FMT_SPECTRUM);
    endtask

    // random blocks, mostly well formed, some noise and broken framing
    task automatic test_random_blocks(input int n_items);
        int sent;
        int mids;
        int kind;
        logic [7:0] flag;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 8)
            begin
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                mids = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
                flag = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
                // broken blocks drop their first or their last word
                if (kind >= 14 || kind < 11)
                begin
                    send_byte(flag, 1'b1, 1'b0);
                    sent++;
                end
                repeat (mids)
                begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                    sent++;
                end
                if (kind >= 11)
                begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                    sent++;
                end
            end
            // occasional setting change while idle
            if ($urandom_range(0, 99) < 12)
            begin
                drain();
                write_reg(CFG_FAST_MODE, 1'($urandom_range(0, 1)));
                write_reg(CFG_TAPE_FORMAT, ($urandom_range(0, 99) < 35) ? FMT_ZX81 : FMT_SPECTRUM);
            end
        end
    endtask

    // test sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(0, 0);
        test_spectrum_header();
        test_spectrum_data_blocks();
        test_fast_pilot();
        test_zx81_blocks();

        set_idling(0, 0);
        test_random_blocks(60);
        set_idling(69, 0);
        test_random_blocks(60);
        set_idling(0, 69);
        test_random_blocks(60);
        set_idling(26, 26);
        test_random_blocks(60);

        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && tape_run_q.size() == 0)
            $display("tb_tape_block_symbol_encoder_core: PASS");
        else
            $display("tb_tape_block_symbol_encoder_core: FAIL");
        $finish;
    end

endmodule

[files.f]
design/tbse_pkg.sv
design/tbse_front.sv
design/tbse_cmd_queue.sv
design/tbse_back.sv
design/tape_block_symbol_encoder_core.sv
tb/sv/tb_tape_block_symbol_encoder_core.sv
